FILE: hw/rtl/dfc_pkg.sv
// Package with the shared types, constants and helpers of the dinucleotide frequency counter.
package dfc_pkg;

   localparam int COUNT_WIDTH  = 16;
   localparam int OUT_WIDTH    = 16;
   localparam int NUM_BASES    = 4;
   localparam int NUM_PAIRS    = 16;
   localparam int SEL_WIDTH    = 5;
   localparam int PSEUDO_WIDTH = 4;

   localparam logic [SEL_WIDTH-1:0]    SEL_PAIR_BASE = SEL_WIDTH'(NUM_BASES);
   localparam logic [SEL_WIDTH-1:0]    SEL_END       = SEL_WIDTH'(NUM_BASES + NUM_PAIRS);
   localparam logic [PSEUDO_WIDTH-1:0] PSEUDO_RESET  = PSEUDO_WIDTH'(1);
   localparam logic [OUT_WIDTH-1:0]    OUT_MAX       = '1;
   localparam logic [COUNT_WIDTH-1:0]  COUNT_MAX     = '1;

   localparam logic [7:0] CHAR_GAP     = 8'h2D;
   localparam logic [7:0] CHAR_A       = 8'h41;
   localparam logic [7:0] CHAR_C       = 8'h43;
   localparam logic [7:0] CHAR_G       = 8'h47;
   localparam logic [7:0] CHAR_T       = 8'h54;
   localparam logic [7:0] CHAR_LOW_A   = 8'h61;
   localparam logic [7:0] CHAR_LOW_Z   = 8'h7A;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;

   typedef enum logic [1:0] {
      MODE_PUSH   = 2'd0,
      MODE_READ   = 2'd1,
      MODE_CLEAR  = 2'd2,
      MODE_IGNORE = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      BASE_A = 2'd0,
      BASE_C = 2'd1,
      BASE_G = 2'd2,
      BASE_T = 2'd3
   } base_type;

   typedef logic [COUNT_WIDTH-1:0] count_type;

   typedef struct packed {
      logic [1:0]           mode;
      logic [7:0]           symbol;
      logic [1:0]           random_pick;
      logic [SEL_WIDTH-1:0] counter_select;
   } req_type;

   typedef struct packed {
      logic [OUT_WIDTH-1:0] count_value;
      logic [SEL_WIDTH-1:0] selected_index;
   } rsp_type;

   typedef struct packed {
      logic     is_gap;
      base_type base;
   } sym_type;

   function automatic count_type sat_inc(input count_type v);
      count_type r;
      if (v == COUNT_MAX) begin
         r = v;
      end else begin
         r = v + count_type'(1);
      end
      return r;
   endfunction

   function automatic logic [OUT_WIDTH-1:0] sat_out(input count_type v);
      logic [OUT_WIDTH-1:0] r;
      if (32'(v) > 32'(OUT_MAX)) begin
         r = OUT_MAX;
      end else begin
         r = OUT_WIDTH'(v);
      end
      return r;
   endfunction

endpackage

FILE: hw/rtl/dfc_sym_decode.sv
// Symbol decoder: folds case and maps an ASCII character to a gap flag and a base.
module dfc_sym_decode
   import dfc_pkg::*;
(
   input  logic [7:0] symbol,
   input  logic [1:0] random_pick,
   output sym_type    decoded
);

   logic [7:0] upper;

   always_comb begin
      if (symbol >= CHAR_LOW_A && symbol <= CHAR_LOW_Z) begin
         upper = symbol - CASE_OFFSET;
      end else begin
         upper = symbol;
      end

      decoded.is_gap = (upper == CHAR_GAP);
      // Anything that is not a known base takes the supplied random base.
      priority if (upper == CHAR_A) begin
         decoded.base = BASE_A;
      end else if (upper == CHAR_C) begin
         decoded.base = BASE_C;
      end else if (upper == CHAR_G) begin
         decoded.base = BASE_G;
      end else if (upper == CHAR_T) begin
         decoded.base = BASE_T;
      end else begin
         decoded.base = base_type'(random_pick);
      end
   end

endmodule

FILE: hw/rtl/dinucleotide_frequency_counter_unit.sv
// Top level of the dinucleotide frequency counter.
//
// Items arrive on the req_ channel (valid/ready) as one beat each: mode 0
// pushes one sequence character, mode 1 reads one counter, mode 2 clears
// all counters and starts a new sequence, mode 3 does nothing. Only a read
// produces a beat on the rsp_ channel, carrying the counter value
// (saturated to 16 bits) and the echoed select.
// An accepted beat is held in an item register; from there it updates the
// counters, and a read loads the result register, whose answer is then
// offered on the rsp_ channel. One beat can be accepted every cycle
// unless a read waits in the item register; the result register
// decouples the two channels.
// When the receiver stalls with a result pending, a read in the item
// register waits, and req_ready drops once that register is full; pushes
// and clears keep flowing while the pending result is waiting.
// Reset empties both registers, zeroes the base counters, loads the pair
// counters and the pseudocount register with one, and forgets the previous
// base. csr_write_data sets the pseudocount used by the next clear.
module dinucleotide_frequency_counter_unit
   import dfc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  req_type                 req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output rsp_type                 rsp_data,
   input  logic                    csr_write_enable,
   input  logic [PSEUDO_WIDTH-1:0] csr_write_data
);

   logic                    item_valid_ff, item_valid_in;
   req_type                 item_ff, item_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;
   logic [PSEUDO_WIDTH-1:0] pseudo_ff, pseudo_in;
   count_type               base_ff [NUM_BASES];
   count_type               base_in [NUM_BASES];
   count_type               pair_ff [NUM_PAIRS];
   count_type               pair_in [NUM_PAIRS];
   base_type                prev_ff, prev_in;
   logic                    have_prev_ff, have_prev_in;

   logic                    item_go;
   mode_type                item_mode;
   sym_type                 sym;
   logic [SEL_WIDTH-1:0]    pair_sel;
   logic [3:0]              pair_idx;
   count_type               read_value;

   dfc_sym_decode u_decode (
      .symbol      (item_ff.symbol),
      .random_pick (item_ff.random_pick),
      .decoded     (sym)
   );

   assign item_mode = mode_type'(item_ff.mode);
   // A read can leave the item register only when the result slot frees up.
   assign item_go   = item_valid_ff &&
                      (item_mode != MODE_READ || !rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || item_go;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign pair_sel  = item_ff.counter_select - SEL_PAIR_BASE;
   assign pair_idx  = {prev_ff, sym.base};

   always_comb begin
      if (item_ff.counter_select < SEL_PAIR_BASE) begin
         read_value = base_ff[item_ff.counter_select[1:0]];
      end else if (item_ff.counter_select < SEL_END) begin
         read_value = pair_ff[pair_sel[3:0]];
      end else begin
         read_value = '0;
      end
   end

   always_comb begin
      item_valid_in = item_valid_ff;
      item_in       = item_ff;
      if (req_valid && req_ready) begin
         item_valid_in = 1'b1;
         item_in       = req_data;
      end else if (item_go) begin
         item_valid_in = 1'b0;
      end

      pseudo_in = csr_write_enable ? csr_write_data : pseudo_ff;

      base_in      = base_ff;
      pair_in      = pair_ff;
      prev_in      = prev_ff;
      have_prev_in = have_prev_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;

      if (item_go) begin
         unique case (item_mode)
            MODE_PUSH: begin
               if (!sym.is_gap) begin
                  base_in[sym.base] = sat_inc(base_ff[sym.base]);
                  if (have_prev_ff) begin
                     pair_in[pair_idx] = sat_inc(pair_ff[pair_idx]);
                  end
                  prev_in      = sym.base;
                  have_prev_in = 1'b1;
               end
            end
            MODE_READ: begin
               rsp_valid_in          = 1'b1;
               rsp_in.count_value    = sat_out(read_value);
               rsp_in.selected_index = item_ff.counter_select;
            end
            MODE_CLEAR: begin
               for (int i = 0; i < NUM_BASES; i++) begin
                  base_in[i] = '0;
               end
               for (int i = 0; i < NUM_PAIRS; i++) begin
                  pair_in[i] = COUNT_WIDTH'(pseudo_ff);
               end
               prev_in      = BASE_A;
               have_prev_in = 1'b0;
            end
            MODE_IGNORE: begin
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         pseudo_ff     <= PSEUDO_RESET;
         prev_ff       <= BASE_A;
         have_prev_ff  <= 1'b0;
         for (int i = 0; i < NUM_BASES; i++) begin
            base_ff[i] <= '0;
         end
         for (int i = 0; i < NUM_PAIRS; i++) begin
            pair_ff[i] <= COUNT_WIDTH'(PSEUDO_RESET);
         end
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         pseudo_ff     <= pseudo_in;
         prev_ff       <= prev_in;
         have_prev_ff  <= have_prev_in;
         base_ff       <= base_in;
         pair_ff       <= pair_in;
      end
   end

endmodule

FILE: tb/dinucleotide_frequency_counter_unit_test.sv
// Self-checking testbench for the dinucleotide frequency counter unit.
`timescale 1ns / 1ps

module dinucleotide_frequency_counter_unit_test;
   import dfc_pkg::*;

   localparam int STALL_LIMIT  = 3000;
   localparam int HOLD_CYCLES  = 300;
   localparam int SETTLE_CYCLES = 4;
   localparam int RUN_PUSHES = 40;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   req_type                 req_data = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   rsp_type                 rsp_data;
   logic                    csr_write_enable = 1'b0;
   logic [PSEUDO_WIDTH-1:0] csr_write_data = '0;

   // Stimulus feed and bookkeeping.
   req_type    char_queue[$];
   int         items_queued = 0;
   int         items_accepted = 0;
   logic       req_taken = 1'b0;
   int         idle_pct = 28;
   int         holds_asked = 0;
   int         holds_served = 0;
   int         hold_left = 0;
   int         quiet_cycles = 0;
   int         mismatch_count = 0;

   // Predicted state of the counters.
   count_type              base_tally [NUM_BASES];
   count_type              pair_tally [NUM_PAIRS];
   base_type               last_base;
   logic                   last_valid;
   logic [PSEUDO_WIDTH-1:0] pseudo_now;
   rsp_type                read_answers[$];
   int                     reads_outstanding = 0;
   rsp_type                want;

   dinucleotide_frequency_counter_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic count_type bump_sat(input count_type v);
      count_type r;
      r = (v == '1) ? v : v + count_type'(1);
      return r;
   endfunction

   task automatic restart_tally();
      for (int i = 0; i < NUM_BASES; i++) begin
         base_tally[i] = '0;
      end
      for (int i = 0; i < NUM_PAIRS; i++) begin
         pair_tally[i] = count_type'(pseudo_now);
      end
      last_base = BASE_A;
      last_valid = 1'b0;
   endtask

   // Advances the predicted counters by one accepted beat and records the
   // answer a read should bring back.
   task automatic tally_item(input req_type item);
      logic [7:0]           ch;
      base_type             b;
      count_type            v;
      rsp_type              ans;
      logic [SEL_WIDTH-1:0] pair_sel;
      case (item.mode)
         MODE_PUSH: begin
            ch = item.symbol;
            if (ch >= CHAR_LOW_A && ch <= CHAR_LOW_Z) begin
               ch = ch - CASE_OFFSET;
            end
            // A gap leaves every counter and the previous base alone.
            if (ch != CHAR_GAP) begin
               case (ch)
                  CHAR_A:  b = BASE_A;
                  CHAR_C:  b = BASE_C;
                  CHAR_G:  b = BASE_G;
                  CHAR_T:  b = BASE_T;
                  default: b = base_type'(item.random_pick);
               endcase
               base_tally[b] = bump_sat(base_tally[b]);
               if (last_valid) begin
                  pair_tally[{last_base, b}] = bump_sat(pair_tally[{last_base, b}]);
               end
               last_base = b;
               last_valid = 1'b1;
            end
         end
         MODE_READ: begin
            pair_sel = item.counter_select - SEL_PAIR_BASE;
            if (item.counter_select < SEL_PAIR_BASE) begin
               v = base_tally[item.counter_select[1:0]];
            end else if (item.counter_select < SEL_END) begin
               v = pair_tally[pair_sel[3:0]];
            end else begin
               v = '0;
            end
            ans.count_value = v;
            ans.selected_index = item.counter_select;
            read_answers.push_back(ans);
            reads_outstanding++;
         end
         MODE_CLEAR: begin
            restart_tally();
         end
         default: begin
         end
      endcase
   endtask

   // Driver: offers the next queued beat, with random gaps.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
      end else if (!req_valid || req_taken) begin
         if (char_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
            req_valid <= 1'b1;
            req_data <= char_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls plus long hold-offs on request.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (holds_served != holds_asked) begin
         holds_served++;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= idle_pct);
      end
   end

   // Monitor: predicts on accepted requests, checks accepted results.
   always @(posedge clock) begin
      req_taken <= req_valid && req_ready;
      if (reset) begin
         pseudo_now = PSEUDO_RESET;
         restart_tally();
         quiet_cycles = 0;
      end else begin
         if (csr_write_enable) begin
            pseudo_now = csr_write_data;
         end
         if (req_valid && req_ready) begin
            tally_item(req_data);
            items_accepted++;
         end
         if (rsp_valid && rsp_ready) begin
            if (read_answers.size() == 0) begin
               $error("unexpected result beat, selected_index %0d",
                      rsp_data.selected_index);
               mismatch_count++;
            end else begin
               want = read_answers.pop_front();
               reads_outstanding--;
               if (rsp_data.count_value !== want.count_value) begin
                  $error("count_value: expected %0d, actual %0d",
                         want.count_value, rsp_data.count_value);
                  mismatch_count++;
               end
               if (rsp_data.selected_index !== want.selected_index) begin
                  $error("selected_index: expected %0d, actual %0d",
                         want.selected_index, rsp_data.selected_index);
                  mismatch_count++;
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
               $display("SCOREBOARD MISMATCH");
               $finish;
            end
         end
      end
   end

   task automatic send(input logic [1:0] mode, input logic [7:0] sym,
                       input logic [1:0] pick, input logic [SEL_WIDTH-1:0] sel);
      req_type item;
      item.mode = mode;
      item.symbol = sym;
      item.random_pick = pick;
      item.counter_select = sel;
      char_queue.push_back(item);
      items_queued++;
   endtask

   // Mostly sequence text with reads mixed in; the ignored mode does not
   // count toward the total.
   task automatic send_random(input int count);
      string   dna = "ACGTacgt-";
      req_type item;
      int      roll;
      int      done;
      done = 0;
      while (done < count) begin
         roll = $urandom_range(99);
         item.symbol = 8'($urandom_range(255));
         item.random_pick = 2'($urandom_range(3));
         item.counter_select = SEL_WIDTH'($urandom_range(31));
         if (roll < 64) begin
            item.mode = MODE_PUSH;
            if ($urandom_range(9) < 7) begin
               item.symbol = dna[$urandom_range(8)];
            end
         end else if (roll < 92) begin
            item.mode = MODE_READ;
            if ($urandom_range(9) < 8) begin
               item.counter_select = SEL_WIDTH'($urandom_range(19));
            end
         end else if (roll < 96) begin
            item.mode = MODE_CLEAR;
         end else begin
            item.mode = MODE_IGNORE;
         end
         if (item.mode != MODE_IGNORE) begin
            done++;
         end
         char_queue.push_back(item);
         items_queued++;
      end
   endtask

   // Returns once every beat is taken, every read answered and the
   // pipeline has had time to retire trailing pushes and clears.
   task automatic wait_quiet();
      wait (items_accepted == items_queued);
      wait (reads_outstanding == 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      logic [PSEUDO_WIDTH-1:0] pseudo_pick;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed beats under the reset pseudocount.
      send(MODE_READ, 8'h00, 2'd0, 5'd0);
      send(MODE_READ, 8'h00, 2'd0, 5'd4);
      send(MODE_PUSH, CHAR_A, 2'd3, 5'd0);
      send(MODE_PUSH, "c", 2'd2, 5'd0);
      send(MODE_PUSH, CHAR_GAP, 2'd1, 5'd0);
      send(MODE_PUSH, CHAR_GAP, 2'd0, 5'd0);
      send(MODE_PUSH, "g", 2'd3, 5'd0);
      send(MODE_PUSH, CHAR_T, 2'd0, 5'd0);
      send(MODE_PUSH, "N", 2'd2, 5'd0);
      send(MODE_PUSH, "x", 2'd1, 5'd0);
      send(MODE_PUSH, 8'hFF, 2'd3, 5'd31);
      send(MODE_PUSH, 8'h00, 2'd0, 5'd0);
      send(MODE_PUSH, "{", 2'd2, 5'd0);
      send(MODE_IGNORE, 8'hFF, 2'd3, 5'd31);
      send(MODE_READ, 8'h00, 2'd0, 5'd1);
      send(MODE_READ, 8'h00, 2'd0, 5'd6);
      send(MODE_READ, 8'h00, 2'd0, 5'd19);
      send(MODE_READ, 8'h00, 2'd0, 5'd20);
      send(MODE_READ, 8'hFF, 2'd3, 5'd31);
      send(MODE_CLEAR, 8'h00, 2'd0, 5'd0);
      send(MODE_PUSH, CHAR_GAP, 2'd0, 5'd0);
      send(MODE_PUSH, CHAR_G, 2'd0, 5'd0);
      send(MODE_READ, 8'h00, 2'd0, 5'd2);
      send(MODE_READ, 8'h00, 2'd0, 5'd14);
      send(MODE_READ, 8'h00, 2'd0, 5'd15);

      for (int p = 0; p < 6; p++) begin
         wait_quiet();
         case (p)
            0, 4:    pseudo_pick = '1;
            1:       pseudo_pick = '0;
            default: pseudo_pick = PSEUDO_WIDTH'($urandom_range(15));
         endcase
         csr_write_enable <= 1'b1;
         csr_write_data <= pseudo_pick;
         @(negedge clock);
         csr_write_enable <= 1'b0;
         // The new pseudocount must not show until the clear.
         send(MODE_READ, 8'h00, 2'd0, SEL_WIDTH'($urandom_range(4, 19)));
         send(MODE_READ, 8'h00, 2'd0, SEL_WIDTH'($urandom_range(4, 19)));
         send(MODE_CLEAR, 8'h00, 2'd0, 5'd0);
         case (p)
            0: begin
               send_random(150);
               wait_quiet();
               // Long receiver hold-off while reads pile up behind it.
               holds_asked++;
               for (int i = 0; i < 60; i++) begin
                  send(MODE_READ, 8'h00, 2'd0, SEL_WIDTH'($urandom_range(31)));
               end
               send_random(150);
            end
            1: begin
               idle_pct = 0;
               send_random(300);
               wait_quiet();
               idle_pct = 28;
            end
            4: begin
               // A long run of base A builds up base A and pair AA.
               for (int i = 0; i < RUN_PUSHES; i++) begin
                  send(MODE_PUSH, ($urandom_range(1) != 0) ? "a" : CHAR_A,
                       2'($urandom_range(3)), 5'd0);
               end
               send(MODE_READ, 8'h00, 2'd0, 5'd0);
               send(MODE_READ, 8'h00, 2'd0, 5'd4);
               send(MODE_PUSH, CHAR_C, 2'd0, 5'd0);
               send(MODE_READ, 8'h00, 2'd0, 5'd1);
               send(MODE_READ, 8'h00, 2'd0, 5'd5);
               send_random(100);
            end
            default: begin
               send_random(330);
            end
         endcase
      end

      wait_quiet();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
